// ===== hw/rtl/frg_pkg.sv =====
// ============================================================================
// frg_pkg
// Shared types and constants for the fraction reducer with Euclid's GCD.
// ============================================================================
package frg_pkg;

    // Fraction bits of the fixed-point quotient.
    localparam int FRAC_BITS = 16;
    // Width of each reduced result field.
    localparam int RES_W     = 16;
    // Width of the fixed-point quotient field.
    localparam int QUOT_W    = 32;
    // Output item width: 16 + 16 + 1 + 32 + 1 = 66 bits, padded to 72.
    localparam int OUT_W     = 72;
    // Width of the divider step count (enough for 32 + 16 steps).
    localparam int STEP_W    = 6;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GCD_WAIT,
        ST_RNUM_WAIT,
        ST_RDEN_WAIT,
        ST_QUOT_WAIT,
        ST_FINISH
    } state_t;

    // Request to the bit-serial divider.
    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } div_req_t;

endpackage

// ===== hw/rtl/fraction_reducer_gcd_unit.sv =====
// ============================================================================
// fraction_reducer_gcd_unit
// Reduces a signed fraction by Euclid's GCD and gives its fixed-point value.
// ============================================================================
// Usage:
//   An item enters on the s_axis channel (numerator, denominator, sign flag)
//   and one result item leaves on the m_axis channel for every input item.
//   Items are worked on one at a time; s_axis_tready is high only while the
//   block is free.
//   All arithmetic runs through one bit-serial divider that resolves one
//   quotient bit per cycle. With W = VALUE_WIDTH, the number of Euclid
//   remainder steps is at most 23 for W = 16. The divider runs these steps,
//   then divides numerator and denominator by the GCD, then forms the
//   fixed-point quotient; the result is then loaded into the output register
//   and the next item can be accepted. A zero denominator skips the divider:
//   the controller goes from the accept straight to loading its result.
//   The result sits in an output register: the next item is accepted while
//   an earlier result still waits. If the receiver stalls with the output
//   register full, the finished result is held back until it drains.
//   Reset clears the controller and empties the output register.
// ============================================================================
module fraction_reducer_gcd_unit #(
    parameter int VALUE_WIDTH = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // numerator, denominator, sign_flag, zero padding
    input  logic [((2*VALUE_WIDTH+1+7)/8)*8-1:0]    s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // reduced_numerator, reduced_denominator, is_negative, quotient_fixed,
    // divide_error, zero padding
    output logic [frg_pkg::OUT_W-1:0]               m_axis_tdata
);
    import frg_pkg::*;

    localparam int W  = VALUE_WIDTH;
    localparam int DW = VALUE_WIDTH + FRAC_BITS;

    state_t state_reg;
    state_t state_next;

    logic [W-1:0]      num_reg;
    logic [W-1:0]      den_reg;
    logic [W-1:0]      b_reg;
    logic              neg_reg;
    logic              err_reg;
    logic [RES_W-1:0]  rnum_reg;
    logic [RES_W-1:0]  rden_reg;
    logic [QUOT_W-1:0] quot_reg;
    logic              out_valid_reg;
    logic [OUT_W-1:0]  out_data_reg;

    logic [W-1:0]  in_num;
    logic [W-1:0]  in_den;
    logic          in_sign;
    logic          in_take;
    logic          out_load;

    div_req_t      div_req;
    logic [DW-1:0] div_dividend;
    logic [W-1:0]  div_divisor;
    logic          div_done;
    logic [DW-1:0] div_quot;
    logic [W-1:0]  div_rem;
    logic [QUOT_W-1:0] quot_sat;

    // Input item fields.
    assign in_num  = s_axis_tdata[W-1:0];
    assign in_den  = s_axis_tdata[2*W-1:W];
    assign in_sign = s_axis_tdata[2*W];
    assign in_take = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = (state_reg == ST_IDLE);

    // Saturate the quotient to 32 bits where it can be wider.
    generate
        if (DW > QUOT_W)
        begin : g_sat
            assign quot_sat = (|div_quot[DW-1:QUOT_W]) ? '1 : div_quot[QUOT_W-1:0];
        end
        else
        begin : g_ext
            assign quot_sat = QUOT_W'(div_quot);
        end
    endgenerate

    frg_div #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (div_req),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and divider requests.
    always_comb
    begin
        state_next    = state_reg;
        div_req.start = 1'b0;
        div_req.steps = STEP_W'(W);
        div_dividend  = {num_reg, FRAC_BITS'(0)};
        div_divisor   = den_reg;
        out_load      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    if (in_den == '0)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        // First remainder step: numerator mod denominator.
                        div_req.start = 1'b1;
                        div_dividend  = {in_num, FRAC_BITS'(0)};
                        div_divisor   = in_den;
                        state_next    = ST_GCD_WAIT;
                    end
                end
            end
            ST_GCD_WAIT:
            begin
                if (div_done)
                begin
                    div_req.start = 1'b1;
                    if (div_rem == '0)
                    begin
                        // The divisor of this step is the GCD.
                        div_dividend = {num_reg, FRAC_BITS'(0)};
                        div_divisor  = b_reg;
                        state_next   = ST_RNUM_WAIT;
                    end
                    else
                    begin
                        div_dividend = {b_reg, FRAC_BITS'(0)};
                        div_divisor  = div_rem;
                    end
                end
            end
            ST_RNUM_WAIT:
            begin
                if (div_done)
                begin
                    div_req.start = 1'b1;
                    div_dividend  = {den_reg, FRAC_BITS'(0)};
                    div_divisor   = b_reg;
                    state_next    = ST_RDEN_WAIT;
                end
            end
            ST_RDEN_WAIT:
            begin
                if (div_done)
                begin
                    // Full-width run gives numerator * 2^16 / denominator.
                    div_req.start = 1'b1;
                    div_req.steps = STEP_W'(DW);
                    div_dividend  = {num_reg, FRAC_BITS'(0)};
                    div_divisor   = den_reg;
                    state_next    = ST_QUOT_WAIT;
                end
            end
            ST_QUOT_WAIT:
            begin
                if (div_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Working registers of the current item.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            num_reg <= in_num;
            den_reg <= in_den;
            b_reg   <= in_den;
            neg_reg <= ~in_sign;
            err_reg <= (in_den == '0);
        end
        if (state_reg == ST_GCD_WAIT && div_done && div_rem != '0)
        begin
            b_reg <= div_rem;
        end
        if (state_reg == ST_RNUM_WAIT && div_done)
        begin
            rnum_reg <= div_quot[RES_W-1:0];
        end
        if (state_reg == ST_RDEN_WAIT && div_done)
        begin
            rden_reg <= div_quot[RES_W-1:0];
        end
        if (state_reg == ST_QUOT_WAIT && div_done)
        begin
            quot_reg <= quot_sat;
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output item; a zero denominator forces the numeric fields to zero.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (err_reg)
            begin
                out_data_reg <= OUT_W'({1'b1, QUOT_W'(0), neg_reg,
                                        RES_W'(0), RES_W'(0)});
            end
            else
            begin
                out_data_reg <= OUT_W'({1'b0, quot_reg, neg_reg, rden_reg, rnum_reg});
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// ===== hw/rtl/frg_div.sv =====
// ============================================================================
// frg_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ============================================================================
module frg_div #(
    parameter int VALUE_WIDTH = 16
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  frg_pkg::div_req_t                             req,
    input  logic [VALUE_WIDTH+frg_pkg::FRAC_BITS-1:0]     dividend,
    input  logic [VALUE_WIDTH-1:0]                        divisor,
    output logic                                          done,
    output logic [VALUE_WIDTH+frg_pkg::FRAC_BITS-1:0]     quotient,
    output logic [VALUE_WIDTH-1:0]                        remainder
);
    import frg_pkg::*;

    localparam int DW = VALUE_WIDTH + FRAC_BITS;

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [DW-1:0]     dvd_reg;
    logic [VALUE_WIDTH-1:0] rem_reg;
    logic [VALUE_WIDTH-1:0] dsr_reg;

    logic [VALUE_WIDTH:0]   shifted;
    logic [VALUE_WIDTH:0]   trial;
    logic                   ge;
    logic [VALUE_WIDTH-1:0] rem_next;
    logic [DW-1:0]          dvd_next;

    // One restoring step: bring in the next dividend bit and try a subtract.
    always_comb
    begin
        shifted  = {rem_reg, dvd_reg[DW-1]};
        trial    = shifted - {1'b0, dsr_reg};
        ge       = (shifted >= {1'b0, dsr_reg});
        rem_next = ge ? trial[VALUE_WIDTH-1:0] : shifted[VALUE_WIDTH-1:0];
        dvd_next = {dvd_reg[DW-2:0], ge};
    end

    // Control: step counter, busy and a one-cycle done pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= req.steps;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - STEP_W'(1);
            if (cnt_reg == STEP_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Data path: the dividend register fills with quotient bits from below.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = dvd_reg;
    assign remainder = rem_reg;

endmodule

// ===== hw/rtl/frg_check.sv =====
// ============================================================================
// frg_check
// Port-level checks for the fraction reducer, bound to the top level.
// ============================================================================
module frg_check (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     s_axis_tvalid,
    input logic                     s_axis_tready,
    input logic                     m_axis_tvalid,
    input logic                     m_axis_tready,
    input logic [frg_pkg::OUT_W-1:0] m_axis_tdata
);
    import frg_pkg::*;

    localparam int NEG_BIT  = 2 * RES_W;
    localparam int QUOT_LSB = NEG_BIT + 1;
    localparam int ERR_BIT  = QUOT_LSB + QUOT_W;

    // A stalled result item stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result item dropped while stalled");

    // A divide error carries zero in every numeric field.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[ERR_BIT] |->
            (m_axis_tdata[NEG_BIT-1:0] == '0) &&
            (m_axis_tdata[ERR_BIT-1:QUOT_LSB] == '0))
        else $error("divide error with nonzero result fields");

    // Items are taken one at a time: the input closes after an accept.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while an item is in progress");

    // No result can appear in the cycle straight after an accept.
    a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
        else $error("result item appeared too early");

endmodule

bind fraction_reducer_gcd_unit frg_check u_frg_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
